/* hdl/spsc_pkg.sv */
// shared types, register codes and constants for the sar sigma-0 calibrator
// depends on nothing; every other file of the block uses it by scoped names
package spsc_pkg;

    localparam int CFG_ADDR_BITS = 6;
    localparam int CFG_DATA_BITS = 64;

    localparam logic [2:0] REG_NOISE_SCALE  = 3'd0;
    localparam logic [2:0] REG_POWER_GAIN   = 3'd1;
    localparam logic [2:0] REG_POWER_OFFSET = 3'd2;
    localparam logic [2:0] REG_GAMMA_MODE   = 3'd3;
    localparam logic [2:0] REG_DB_FLOOR     = 3'd4;
    localparam logic [2:0] REG_DB_CEILING   = 3'd5;

    localparam logic signed [15:0] DB_FLOOR_RESET = -16'sd6528;
    localparam logic [17:0] TEN_LOG10_2_Q16 = 18'd197283;

    typedef struct packed {
        logic vld;
        logic force_zero;
        logic force_max;
    } spsc_ctl_t;

    typedef struct packed {
        logic [31:0]        noise_scale;
        logic [55:0]        power_gain;
        logic signed [47:0] power_offset;
        logic               gamma_mode;
        logic signed [15:0] db_floor;
        logic signed [15:0] db_ceiling;
    } spsc_cfg_t;

    // log2(1 + idx/2^addr_bits) truncated to q.16, elaboration-time only
    function automatic logic [15:0] log2_rom_entry(input int idx, input int addr_bits);
        logic [63:0] m;
        logic [15:0] frac;
        m = (64'd1 << 30) + (64'(idx) << (30 - addr_bits));
        frac = '0;
        for (int k = 0; k < 16; k++)
        begin
            m = (m * m) >> 30;
            frac = {frac[14:0], 1'b0};
            if (m >= (64'd2 << 30))
            begin
                frac[0] = 1'b1;
                m = m >> 1;
            end
        end
        return frac;
    endfunction

endpackage

/* hdl/sar_pixel_sigma0_calibrator.sv */
// top level of the sar sigma-0 / gamma-0 calibrator: apb registers, stall control
// depends on spsc_pkg, spsc_power, spsc_log, spsc_map
//
// channel  | signals                                              | role
// pixel    | pixel_valid/ready, amplitude, noise_power, inv_cos_* | word in
// result   | result_valid/ready, calibrated_byte                  | word out
// apb      | psel, penable, pwrite, paddr, pwdata, prdata, pready | registers
//
// one word per cycle while the result is not stalled; 7 power, 2 log, 6 map stages
// the whole pipeline advances together; the last stage is the output register
// a stalled result freezes every stage, bubbles included, nothing is dropped
// reset clears all valid bits and loads register defaults
module sar_pixel_sigma0_calibrator #(
    parameter int LOG_TABLE_ADDR_BITS = 8,
    parameter int AMPLITUDE_BITS = 16
) (
    input  logic                      clk,
    input  logic                      rst_n,
    input  logic                      pixel_valid,
    output logic                      pixel_ready,
    input  logic [AMPLITUDE_BITS-1:0] amplitude,
    input  logic [39:0]               noise_power,
    input  logic [17:0]               inv_cos_incidence,
    output logic                      result_valid,
    input  logic                      result_ready,
    output logic [7:0]                calibrated_byte,
    input  logic                      psel,
    input  logic                      penable,
    input  logic                      pwrite,
    input  logic [spsc_pkg::CFG_ADDR_BITS-1:0] paddr,
    input  logic [spsc_pkg::CFG_DATA_BITS-1:0] pwdata,
    output logic [spsc_pkg::CFG_DATA_BITS-1:0] prdata,
    output logic                      pready
);

    spsc_pkg::spsc_cfg_t cfg_reg;
    spsc_pkg::spsc_ctl_t pwr_ctl, log_ctl;

    logic               en;
    logic [2:0]         reg_idx;
    logic [39:0]        pwr_p;
    logic signed [16:0] log_db;

    assign en          = !result_valid || result_ready;
    assign pixel_ready = en;
    assign pready      = 1'b1;
    assign reg_idx     = paddr[5:3];

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            cfg_reg.noise_scale  <= '0;
            cfg_reg.power_gain   <= '0;
            cfg_reg.power_offset <= '0;
            cfg_reg.gamma_mode   <= 1'b0;
            cfg_reg.db_floor     <= spsc_pkg::DB_FLOOR_RESET;
            cfg_reg.db_ceiling   <= '0;
        end
        else if (psel && penable && pwrite && pready)
        begin
            case (reg_idx)
                spsc_pkg::REG_NOISE_SCALE:  cfg_reg.noise_scale  <= pwdata[31:0];
                spsc_pkg::REG_POWER_GAIN:   cfg_reg.power_gain   <= pwdata[55:0];
                spsc_pkg::REG_POWER_OFFSET: cfg_reg.power_offset <= pwdata[47:0];
                spsc_pkg::REG_GAMMA_MODE:   cfg_reg.gamma_mode   <= pwdata[0];
                spsc_pkg::REG_DB_FLOOR:     cfg_reg.db_floor     <= pwdata[15:0];
                spsc_pkg::REG_DB_CEILING:   cfg_reg.db_ceiling   <= pwdata[15:0];
                default: ;
            endcase
        end
    end

    always_comb
    begin
        case (reg_idx)
            spsc_pkg::REG_NOISE_SCALE:  prdata = 64'(cfg_reg.noise_scale);
            spsc_pkg::REG_POWER_GAIN:   prdata = 64'(cfg_reg.power_gain);
            spsc_pkg::REG_POWER_OFFSET:
                prdata = {{16{cfg_reg.power_offset[47]}}, cfg_reg.power_offset};
            spsc_pkg::REG_GAMMA_MODE:   prdata = 64'(cfg_reg.gamma_mode);
            spsc_pkg::REG_DB_FLOOR:
                prdata = {{48{cfg_reg.db_floor[15]}}, cfg_reg.db_floor};
            spsc_pkg::REG_DB_CEILING:
                prdata = {{48{cfg_reg.db_ceiling[15]}}, cfg_reg.db_ceiling};
            default:                    prdata = '0;
        endcase
    end

    spsc_power #(
        .AMPLITUDE_BITS(AMPLITUDE_BITS)
    ) u_power (
        .clk              (clk),
        .rst_n            (rst_n),
        .en               (en),
        .word_in          (pixel_valid && pixel_ready),
        .amplitude        (amplitude),
        .noise_power      (noise_power),
        .inv_cos_incidence(inv_cos_incidence),
        .cfg              (cfg_reg),
        .ctl              (pwr_ctl),
        .power            (pwr_p)
    );

    spsc_log #(
        .LOG_TABLE_ADDR_BITS(LOG_TABLE_ADDR_BITS)
    ) u_log (
        .clk   (clk),
        .rst_n (rst_n),
        .en    (en),
        .ctl_in(pwr_ctl),
        .power (pwr_p),
        .ctl   (log_ctl),
        .db    (log_db)
    );

    spsc_map u_map (
        .clk            (clk),
        .rst_n          (rst_n),
        .en             (en),
        .ctl_in         (log_ctl),
        .db             (log_db),
        .db_floor       (cfg_reg.db_floor),
        .db_ceiling     (cfg_reg.db_ceiling),
        .vld            (result_valid),
        .calibrated_byte(calibrated_byte)
    );

    a_flags_exclusive: assert property (@(posedge clk) disable iff (!rst_n)
        pwr_ctl.vld |-> !(pwr_ctl.force_zero && pwr_ctl.force_max))
        else $error("power stage forces both zero and full scale");

    a_power_nonzero: assert property (@(posedge clk) disable iff (!rst_n)
        (pwr_ctl.vld && !pwr_ctl.force_zero && !pwr_ctl.force_max) |-> (pwr_p != '0))
        else $error("in-range power has no leading one");

    a_db_nonpositive: assert property (@(posedge clk) disable iff (!rst_n)
        (log_ctl.vld && !log_ctl.force_zero && !log_ctl.force_max) |-> (log_db <= 0))
        else $error("db of power below one is positive");

    a_stall_holds: assert property (@(posedge clk) disable iff (!rst_n)
        (!en && pwr_ctl.vld) |=> (pwr_ctl.vld && $stable(pwr_p)))
        else $error("power stage moved during a stall");

endmodule

/* hdl/spsc_power.sv */
// linear power path: noise removal, gain, offset, gamma correction, range check
// seven register stages; depends on spsc_pkg
module spsc_power #(
    parameter int AMPLITUDE_BITS = 16
) (
    input  logic                      clk,
    input  logic                      rst_n,
    input  logic                      en,
    input  logic                      word_in,
    input  logic [AMPLITUDE_BITS-1:0] amplitude,
    input  logic [39:0]               noise_power,
    input  logic [17:0]               inv_cos_incidence,
    input  spsc_pkg::spsc_cfg_t       cfg,
    output spsc_pkg::spsc_ctl_t       ctl,
    output logic [39:0]               power
);

    localparam int SQ_BITS = 2 * AMPLITUDE_BITS;
    localparam logic signed [64:0] SAT_POS = 65'sd1 <<< 62;
    localparam logic signed [64:0] SAT_NEG = -SAT_POS;

    spsc_pkg::spsc_ctl_t s1_ctl_reg, s2_ctl_reg, s3_ctl_reg, s4_ctl_reg;
    spsc_pkg::spsc_ctl_t s5_ctl_reg, s6_ctl_reg, s7_ctl_reg;
    spsc_pkg::spsc_ctl_t s1_ctl_next, s7_ctl_next;

    logic [SQ_BITS-1:0] s1_sq_reg;
    logic [51:0]        s1_nh_reg, s1_nl_reg;
    logic [17:0]        s1_icos_reg, s2_icos_reg, s3_icos_reg, s4_icos_reg, s5_icos_reg;
    logic [55:0]        s2_mag_reg, s2_mag_next;
    logic               s2_neg_reg, s3_neg_reg, s4_neg_reg, s2_neg_next;
    logic [55:0]        s3_ll_reg, s3_lh_reg, s3_hl_reg, s3_hh_reg;
    logic [111:0]       s4_prod_reg, s4_prod_next;
    logic [63:0]        s5_pwr_reg, s6_pwr_reg, s5_pwr_next;
    logic               s6_use_reg, s6_use_next;
    logic [49:0]        s6_plo_reg;
    logic [48:0]        s6_phi_reg;
    logic [39:0]        s7_p_reg;

    logic [56:0]        an;
    logic [56:0]        sq8;
    logic signed [57:0] diff;
    logic [57:0]        mag_full;
    logic [62:0]        mag63;
    logic signed [64:0] smag, psum;
    logic [80:0]        gprod;
    logic [64:0]        gmag;
    logic [63:0]        pfin;
    logic               nonpos, big;

    always_comb
    begin
        s1_ctl_next.vld        = word_in;
        s1_ctl_next.force_zero = (amplitude == '0);
        s1_ctl_next.force_max  = 1'b0;
    end

    // stage 2: weighted noise off the squared amplitude
    always_comb
    begin
        an = {1'b0, s1_nh_reg, 4'b0} + 57'(s1_nl_reg[51:16]);
        sq8 = 57'({s1_sq_reg, 8'b0});
        diff = $signed({1'b0, sq8}) - $signed({1'b0, an});
        s2_neg_next = diff[57];
        mag_full = s2_neg_next ? 58'(-diff) : 58'(diff);
        s2_mag_next = mag_full[55:0];
    end

    // stage 4: partial product sum
    always_comb
    begin
        s4_prod_next = {s3_hh_reg, 56'b0}
                     + ((112'(s3_lh_reg) + 112'(s3_hl_reg)) << 28)
                     + 112'(s3_ll_reg);
    end

    // stage 5: saturate, sign, offset
    always_comb
    begin
        mag63 = (|s4_prod_reg[111:86]) ? 63'(SAT_POS) : {1'b0, s4_prod_reg[85:24]};
        smag = $signed({2'b0, mag63});
        if (s4_neg_reg)
        begin
            smag = -smag;
        end
        psum = smag + $signed({{17{cfg.power_offset[47]}}, cfg.power_offset});
        if (psum > SAT_POS)
        begin
            psum = SAT_POS;
        end
        else if (psum < SAT_NEG)
        begin
            psum = SAT_NEG;
        end
        s5_pwr_next = psum[63:0];
        s6_use_next = cfg.gamma_mode && !s5_pwr_reg[63] && (s5_pwr_reg != '0);
    end

    // stage 7: gamma product, range check
    always_comb
    begin
        gprod = {s6_phi_reg, 32'b0} + 81'(s6_plo_reg);
        gmag = gprod[80:16];
        if (gmag > 65'(SAT_POS))
        begin
            gmag = 65'(SAT_POS);
        end
        pfin = s6_use_reg ? gmag[63:0] : s6_pwr_reg;
        nonpos = pfin[63] || (pfin == '0);
        big = !pfin[63] && (|pfin[62:40]);
        s7_ctl_next.vld        = s6_ctl_reg.vld;
        s7_ctl_next.force_zero = s6_ctl_reg.force_zero | nonpos;
        s7_ctl_next.force_max  = !s6_ctl_reg.force_zero & big;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            s1_ctl_reg <= '0;
            s2_ctl_reg <= '0;
            s3_ctl_reg <= '0;
            s4_ctl_reg <= '0;
            s5_ctl_reg <= '0;
            s6_ctl_reg <= '0;
            s7_ctl_reg <= '0;
        end
        else if (en)
        begin
            s1_ctl_reg <= s1_ctl_next;
            s2_ctl_reg <= s1_ctl_reg;
            s3_ctl_reg <= s2_ctl_reg;
            s4_ctl_reg <= s3_ctl_reg;
            s5_ctl_reg <= s4_ctl_reg;
            s6_ctl_reg <= s5_ctl_reg;
            s7_ctl_reg <= s7_ctl_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (en)
        begin
            s1_sq_reg   <= SQ_BITS'(amplitude) * SQ_BITS'(amplitude);
            s1_nh_reg   <= 52'(cfg.noise_scale) * 52'(noise_power[39:20]);
            s1_nl_reg   <= 52'(cfg.noise_scale) * 52'(noise_power[19:0]);
            s1_icos_reg <= inv_cos_incidence;
            s2_mag_reg  <= s2_mag_next;
            s2_neg_reg  <= s2_neg_next;
            s2_icos_reg <= s1_icos_reg;
            s3_ll_reg   <= 56'(cfg.power_gain[27:0]) * 56'(s2_mag_reg[27:0]);
            s3_lh_reg   <= 56'(cfg.power_gain[27:0]) * 56'(s2_mag_reg[55:28]);
            s3_hl_reg   <= 56'(cfg.power_gain[55:28]) * 56'(s2_mag_reg[27:0]);
            s3_hh_reg   <= 56'(cfg.power_gain[55:28]) * 56'(s2_mag_reg[55:28]);
            s3_neg_reg  <= s2_neg_reg;
            s3_icos_reg <= s2_icos_reg;
            s4_prod_reg <= s4_prod_next;
            s4_neg_reg  <= s3_neg_reg;
            s4_icos_reg <= s3_icos_reg;
            s5_pwr_reg  <= s5_pwr_next;
            s5_icos_reg <= s4_icos_reg;
            s6_pwr_reg  <= s5_pwr_reg;
            s6_use_reg  <= s6_use_next;
            s6_plo_reg  <= 50'(s5_pwr_reg[31:0]) * 50'(s5_icos_reg);
            s6_phi_reg  <= 49'(s5_pwr_reg[62:32]) * 49'(s5_icos_reg);
            s7_p_reg    <= pfin[39:0];
        end
    end

    assign ctl   = s7_ctl_reg;
    assign power = s7_p_reg;

endmodule

/* hdl/spsc_log.sv */
// power to db: leading-one detect, log2 table, scale by 10*log10(2)
// two register stages; depends on spsc_pkg
module spsc_log #(
    parameter int LOG_TABLE_ADDR_BITS = 8
) (
    input  logic                clk,
    input  logic                rst_n,
    input  logic                en,
    input  spsc_pkg::spsc_ctl_t ctl_in,
    input  logic [39:0]         power,
    output spsc_pkg::spsc_ctl_t ctl,
    output logic signed [16:0]  db
);

    localparam int DEPTH = 1 << LOG_TABLE_ADDR_BITS;

    logic [15:0] rom [DEPTH];

    for (genvar i = 0; i < DEPTH; i++)
    begin : g_rom
        assign rom[i] = spsc_pkg::log2_rom_entry(i, LOG_TABLE_ADDR_BITS);
    end

    spsc_pkg::spsc_ctl_t l1_ctl_reg, l2_ctl_reg;
    logic [21:0]         l1_absl_reg, l1_absl_next;
    logic signed [16:0]  l2_db_reg, l2_db_next;

    logic [5:0]                     lead;
    logic [39:0]                    norm;
    logic [LOG_TABLE_ADDR_BITS-1:0] idx;
    logic [39:0]                    prod;

    always_comb
    begin
        lead = '0;
        for (int i = 0; i < 40; i++)
        begin
            if (power[i])
            begin
                lead = 6'(i);
            end
        end
        norm = power << (6'd39 - lead);
        idx = norm[38 -: LOG_TABLE_ADDR_BITS];
        l1_absl_next = {6'd40 - lead, 16'b0} - {6'b0, rom[idx]};
    end

    always_comb
    begin
        prod = 40'(l1_absl_reg) * 40'(spsc_pkg::TEN_LOG10_2_Q16) + (40'd1 << 23);
        l2_db_next = -$signed({1'b0, prod[39:24]});
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            l1_ctl_reg <= '0;
            l2_ctl_reg <= '0;
        end
        else if (en)
        begin
            l1_ctl_reg <= ctl_in;
            l2_ctl_reg <= l1_ctl_reg;
        end
    end

    always_ff @(posedge clk)
    begin
        if (en)
        begin
            l1_absl_reg <= l1_absl_next;
            l2_db_reg   <= l2_db_next;
        end
    end

    assign ctl = l2_ctl_reg;
    assign db  = l2_db_reg;

endmodule

/* hdl/spsc_map.sv */
// db to byte: floor and range checks, pipelined restoring divide, output register
// six register stages; depends on spsc_pkg
module spsc_map (
    input  logic                clk,
    input  logic                rst_n,
    input  logic                en,
    input  spsc_pkg::spsc_ctl_t ctl_in,
    input  logic signed [16:0]  db,
    input  logic signed [15:0]  db_floor,
    input  logic signed [15:0]  db_ceiling,
    output logic                vld,
    output logic [7:0]          calibrated_byte
);

    localparam int DIV_STAGES = 4;

    spsc_pkg::spsc_ctl_t ctl_reg [DIV_STAGES+1];
    logic [25:0]         rem_reg [DIV_STAGES+1];
    logic [7:0]          quo_reg [DIV_STAGES+1];
    logic [16:0]         den_reg [DIV_STAGES+1];

    spsc_pkg::spsc_ctl_t m1_ctl_next;
    logic [25:0]         m1_rem_next;
    logic [16:0]         m1_den_next;
    logic                out_vld_reg;
    logic [7:0]          out_byte_reg, out_byte_next;

    logic signed [17:0] d;
    logic signed [16:0] span;
    logic [23:0]        num;
    logic               le, spn, ovf;

    always_comb
    begin
        d = $signed({db[16], db}) - $signed({{2{db_floor[15]}}, db_floor});
        span = $signed({db_ceiling[15], db_ceiling}) - $signed({db_floor[15], db_floor});
        le = d[17] || (d == '0);
        spn = span[16] || (span == '0);
        num = {d[15:0], 8'b0} - 24'(d[15:0]);
        m1_rem_next = 26'({num, 1'b0}) + 26'(span[15:0]);
        m1_den_next = {span[15:0], 1'b0};
        ovf = m1_rem_next >= 26'({m1_den_next, 8'b0});
        m1_ctl_next.vld        = ctl_in.vld;
        m1_ctl_next.force_zero = ctl_in.force_zero | (!ctl_in.force_max & le);
        m1_ctl_next.force_max  = !ctl_in.force_zero
                               & (ctl_in.force_max | (!le & (spn | ovf)));
    end

    // two quotient bits per stage
    for (genvar s = 0; s < DIV_STAGES; s++)
    begin : g_div
        localparam int K_HI = 7 - 2 * s;
        localparam int K_LO = 6 - 2 * s;

        logic [25:0] t_hi, t_lo, r_mid, r_out;
        logic [7:0]  q_out;

        always_comb
        begin
            t_hi = 26'(den_reg[s]) << K_HI;
            t_lo = 26'(den_reg[s]) << K_LO;
            q_out = quo_reg[s];
            r_mid = rem_reg[s];
            if (r_mid >= t_hi)
            begin
                r_mid = r_mid - t_hi;
                q_out[K_HI] = 1'b1;
            end
            r_out = r_mid;
            if (r_out >= t_lo)
            begin
                r_out = r_out - t_lo;
                q_out[K_LO] = 1'b1;
            end
        end

        always_ff @(posedge clk or negedge rst_n)
        begin
            if (!rst_n)
            begin
                ctl_reg[s+1] <= '0;
            end
            else if (en)
            begin
                ctl_reg[s+1] <= ctl_reg[s];
            end
        end

        always_ff @(posedge clk)
        begin
            if (en)
            begin
                rem_reg[s+1] <= r_out;
                quo_reg[s+1] <= q_out;
                den_reg[s+1] <= den_reg[s];
            end
        end
    end

    always_comb
    begin
        if (ctl_reg[DIV_STAGES].force_zero)
        begin
            out_byte_next = '0;
        end
        else if (ctl_reg[DIV_STAGES].force_max)
        begin
            out_byte_next = 8'hFF;
        end
        else
        begin
            out_byte_next = quo_reg[DIV_STAGES];
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            ctl_reg[0]  <= '0;
            out_vld_reg <= 1'b0;
        end
        else if (en)
        begin
            ctl_reg[0]  <= m1_ctl_next;
            out_vld_reg <= ctl_reg[DIV_STAGES].vld;
        end
    end

    always_ff @(posedge clk)
    begin
        if (en)
        begin
            rem_reg[0]   <= m1_rem_next;
            quo_reg[0]   <= '0;
            den_reg[0]   <= m1_den_next;
            out_byte_reg <= out_byte_next;
        end
    end

    assign vld             = out_vld_reg;
    assign calibrated_byte = out_byte_reg;

endmodule

/* tb/sv/spsc_checker.sv */
// result checker for the sar sigma-0 calibrator: follows register writes,
// predicts the calibrated byte of every accepted pixel word and compares
// depends on spsc_pkg for the register codes and the dB reset value
module spsc_checker
(
    input  logic        clk,
    input  logic        rst_n,
    input  logic        pixel_valid,
    input  logic        pixel_ready,
    input  logic [15:0] amplitude,
    input  logic [39:0] noise_power,
    input  logic [17:0] inv_cos_incidence,
    input  logic        result_valid,
    input  logic        result_ready,
    input  logic [7:0]  calibrated_byte,
    input  logic        psel,
    input  logic        penable,
    input  logic        pwrite,
    input  logic        pready,
    input  logic [spsc_pkg::CFG_ADDR_BITS-1:0] paddr,
    input  logic [spsc_pkg::CFG_DATA_BITS-1:0] pwdata,
    output int          mismatch_count,
    output int          pending_bytes
);
    timeunit 1ns;
    timeprecision 1ps;

    localparam logic [63:0] POWER_SAT = 64'd1 << 62;
    localparam logic [63:0] ONE_POWER = 64'd1 << 40;

    logic [31:0]        noise_scale;
    logic [55:0]        power_gain;
    logic signed [47:0] power_offset;
    logic               gamma_mode;
    logic signed [15:0] db_floor;
    logic signed [15:0] db_ceiling;

    logic [15:0] log2_frac [256];
    logic [7:0]  byte_queue [$];

    function automatic logic [15:0] log2_frac_of(int idx);
        logic [63:0] m;
        logic [15:0] frac;
        m = (64'd1 << 30) + (64'(idx) << 22);
        frac = '0;
        for (int k = 0; k < 16; k++)
        begin
            m = (m * m) >> 30;
            frac = frac << 1;
            if (m >= (64'd2 << 30))
            begin
                frac[0] = 1'b1;
                m = m >> 1;
            end
        end
        return frac;
    endfunction

    initial
    begin
        for (int i = 0; i < 256; i++)
            log2_frac[i] = log2_frac_of(i);
    end

    function automatic logic [7:0] calibrated_of(logic [15:0] dn, logic [39:0] nz,
                                                  logic [17:0] ic);
        logic [127:0] prod;
        logic [63:0]  an, mag, up, idx;
        longint       diff, pwr, db, span, num;
        int           e;
        logic [31:0]  absl;
        if (dn == 0)
            return 8'd0;
        prod = 128'(noise_scale) * 128'(nz);
        an = 64'(prod >> 16);
        diff = longint'((64'(dn) * 64'(dn)) << 8) - longint'(an);
        mag = (diff < 0) ? 64'(-diff) : 64'(diff);
        prod = 128'(power_gain) * 128'(mag);
        if (prod >= (128'd1 << 86))
            mag = POWER_SAT;
        else
        begin
            mag = 64'(prod >> 24);
            if (mag > POWER_SAT)
                mag = POWER_SAT;
        end
        pwr = (diff < 0) ? -longint'(mag) : longint'(mag);
        pwr = pwr + longint'(power_offset);
        if (pwr > longint'(POWER_SAT))
            pwr = longint'(POWER_SAT);
        if (pwr < -longint'(POWER_SAT))
            pwr = -longint'(POWER_SAT);
        if (gamma_mode && pwr > 0)
        begin
            prod = 128'(64'(pwr)) * 128'(ic);
            if (prod >= (128'd1 << 78))
                pwr = longint'(POWER_SAT);
            else
            begin
                mag = 64'(prod >> 16);
                pwr = (mag > POWER_SAT) ? longint'(POWER_SAT) : longint'(mag);
            end
        end
        if (pwr >= longint'(ONE_POWER))
            return 8'd255;
        if (pwr <= 0)
            return 8'd0;
        up = 64'(pwr);
        e = 39;
        while (e > 0 && up[e] == 1'b0)
            e--;
        idx = (e >= 8) ? (up >> (e - 8)) : (up << (8 - e));
        idx = idx & 64'd255;
        absl = 32'((40 - e) * 65536) - 32'(log2_frac[idx]);
        db = -longint'((64'(absl) * 64'd197283 + (64'd1 << 23)) >> 24);
        if (db <= longint'(db_floor))
            return 8'd0;
        span = longint'(db_ceiling) - longint'(db_floor);
        if (span <= 0)
            return 8'd255;
        num = (db - longint'(db_floor)) * 255;
        num = (2 * num + span) / (2 * span);
        return (num > 255) ? 8'd255 : 8'(num);
    endfunction

    assign pending_bytes = byte_queue.size();

    always @(posedge clk or negedge rst_n)
    begin
        logic [7:0] want;
        if (!rst_n)
        begin
            noise_scale <= '0;
            power_gain <= '0;
            power_offset <= '0;
            gamma_mode <= 1'b0;
            db_floor <= spsc_pkg::DB_FLOOR_RESET;
            db_ceiling <= '0;
            mismatch_count <= 0;
        end
        else
        begin
            if (pixel_valid && pixel_ready)
                byte_queue.push_back(calibrated_of(amplitude, noise_power, inv_cos_incidence));
            if (result_valid && result_ready)
            begin
                if (byte_queue.size() == 0)
                begin
                    if (mismatch_count < 10)
                        $display("unexpected word: calibrated_byte %0d", calibrated_byte);
                    mismatch_count <= mismatch_count + 1;
                end
                else
                begin
                    want = byte_queue.pop_front();
                    if (want !== calibrated_byte)
                    begin
                        if (mismatch_count < 10)
                            $display("mismatch: calibrated_byte expected %0d actual %0d",
                                     want, calibrated_byte);
                        mismatch_count <= mismatch_count + 1;
                    end
                end
            end
            if (psel && penable && pwrite && pready)
            begin
                case (3'(paddr >> 3))
                    spsc_pkg::REG_NOISE_SCALE:  noise_scale <= pwdata[31:0];
                    spsc_pkg::REG_POWER_GAIN:   power_gain <= pwdata[55:0];
                    spsc_pkg::REG_POWER_OFFSET: power_offset <= pwdata[47:0];
                    spsc_pkg::REG_GAMMA_MODE:   gamma_mode <= pwdata[0];
                    spsc_pkg::REG_DB_FLOOR:     db_floor <= pwdata[15:0];
                    spsc_pkg::REG_DB_CEILING:   db_ceiling <= pwdata[15:0];
                    default: ;
                endcase
            end
        end
    end

endmodule

/* tb/sv/tb_top.sv */
// top of the sar sigma-0 calibrator testbench: clock, reset, register
// setup, pixel stimulus and result stalls; depends on spsc_pkg, spsc_checker
module tb_top;
    timeunit 1ns;
    timeprecision 1ps;

    localparam int CYCLE_LIMIT = 400000;

    logic        clk;
    logic        rst_n;
    logic        pixel_valid;
    logic        pixel_ready;
    logic [15:0] amplitude;
    logic [39:0] noise_power;
    logic [17:0] inv_cos_incidence;
    logic        result_valid;
    logic        result_ready;
    logic [7:0]  calibrated_byte;
    logic        psel;
    logic        penable;
    logic        pwrite;
    logic [spsc_pkg::CFG_ADDR_BITS-1:0] paddr;
    logic [spsc_pkg::CFG_DATA_BITS-1:0] pwdata;
    logic [spsc_pkg::CFG_DATA_BITS-1:0] prdata;
    logic        pready;

    int mismatch_count;
    int pending_bytes;
    int cycle_count = 0;
    int burst_left;
    logic hold_request;
    logic hold_done;

    sar_pixel_sigma0_calibrator DUT (
        .clk(clk), .rst_n(rst_n),
        .pixel_valid(pixel_valid), .pixel_ready(pixel_ready),
        .amplitude(amplitude), .noise_power(noise_power),
        .inv_cos_incidence(inv_cos_incidence),
        .result_valid(result_valid), .result_ready(result_ready),
        .calibrated_byte(calibrated_byte),
        .psel(psel), .penable(penable), .pwrite(pwrite), .paddr(paddr),
        .pwdata(pwdata), .prdata(prdata), .pready(pready)
    );

    spsc_checker u_checker (
        .clk(clk), .rst_n(rst_n),
        .pixel_valid(pixel_valid), .pixel_ready(pixel_ready),
        .amplitude(amplitude), .noise_power(noise_power),
        .inv_cos_incidence(inv_cos_incidence),
        .result_valid(result_valid), .result_ready(result_ready),
        .calibrated_byte(calibrated_byte),
        .psel(psel), .penable(penable), .pwrite(pwrite), .pready(pready),
        .paddr(paddr), .pwdata(pwdata),
        .mismatch_count(mismatch_count), .pending_bytes(pending_bytes)
    );

    always
    begin
        clk = 1'b1;
        #6;
        clk = 1'b0;
        #6;
    end

    always @(posedge clk)
    begin
        cycle_count <= cycle_count + 1;
        if (cycle_count > CYCLE_LIMIT)
        begin
            $display("DONE: errors detected");
            $finish;
        end
    end

    // receiver stalls, with one long hold-off on request
    always @(posedge clk)
    begin
        int run_left;
        int stall_pct;
        int hold_left;
        if (!rst_n)
        begin
            run_left = 0;
            stall_pct = 0;
            hold_left = 0;
            hold_done <= 1'b0;
            result_ready <= 1'b0;
        end
        else if (hold_request && !hold_done && hold_left == 0)
        begin
            hold_left = 400;
            hold_done <= 1'b1;
            result_ready <= 1'b0;
        end
        else if (hold_left > 0)
        begin
            hold_left--;
            result_ready <= 1'b0;
        end
        else
        begin
            if (run_left == 0)
            begin
                run_left = $urandom_range(10, 200);
                stall_pct = ($urandom_range(0, 2) == 0) ? 0 : $urandom_range(10, 80);
            end
            run_left--;
            result_ready <= ($urandom_range(0, 99) >= stall_pct);
        end
    end

    task automatic cfg_write(logic [2:0] reg_idx, logic [63:0] value);
        @(posedge clk);
        psel <= 1'b1;
        penable <= 1'b0;
        pwrite <= 1'b1;
        paddr <= spsc_pkg::CFG_ADDR_BITS'(reg_idx) << 3;
        pwdata <= value;
        @(posedge clk);
        penable <= 1'b1;
        @(posedge clk);
        psel <= 1'b0;
        penable <= 1'b0;
        pwrite <= 1'b0;
    endtask

    task automatic cfg_all(logic [31:0] ns, logic [55:0] gain, logic [47:0] offs,
                           logic gm, logic [15:0] flo, logic [15:0] ceil_db);
        cfg_write(spsc_pkg::REG_NOISE_SCALE, 64'(ns));
        cfg_write(spsc_pkg::REG_POWER_GAIN, 64'(gain));
        cfg_write(spsc_pkg::REG_POWER_OFFSET, 64'(offs));
        cfg_write(spsc_pkg::REG_GAMMA_MODE, 64'(gm));
        cfg_write(spsc_pkg::REG_DB_FLOOR, 64'(flo));
        cfg_write(spsc_pkg::REG_DB_CEILING, 64'(ceil_db));
    endtask

    // called at a rising edge; returns at the edge that accepts the word
    task automatic send_pixel(logic [15:0] a, logic [39:0] n, logic [17:0] c);
        int gap;
        if (burst_left == 0)
        begin
            pixel_valid <= 1'b0;
            gap = ($urandom_range(0, 3) == 0) ? $urandom_range(5, 30) : $urandom_range(1, 4);
            repeat (gap) @(posedge clk);
            burst_left = ($urandom_range(0, 4) == 0) ? $urandom_range(50, 300)
                                                     : $urandom_range(1, 12);
        end
        burst_left--;
        pixel_valid <= 1'b1;
        amplitude <= a;
        noise_power <= n;
        inv_cos_incidence <= c;
        do
            @(posedge clk);
        while (!pixel_ready);
    endtask

    task automatic send_random_pixel();
        logic [63:0] r;
        logic [15:0] a;
        logic [39:0] n;
        logic [17:0] c;
        r = {$urandom, $urandom};
        a = 16'($urandom) & 16'((32'd1 << $urandom_range(1, 16)) - 1);
        n = r[39:0] >> $urandom_range(0, 40);
        c = ($urandom_range(0, 3) == 0) ? 18'($urandom)
                                        : 18'($urandom_range(65536, 131072));
        send_pixel(a, n, c);
    endtask

    task automatic drain();
        pixel_valid <= 1'b0;
        @(posedge clk);
        while (pending_bytes != 0)
            @(posedge clk);
        repeat (20) @(posedge clk);
    endtask

    initial
    begin
        logic [63:0] r;
        logic signed [15:0] flo;
        rst_n = 1'b0;
        pixel_valid = 1'b0;
        amplitude = '0;
        noise_power = '0;
        inv_cos_incidence = '0;
        psel = 1'b0;
        penable = 1'b0;
        pwrite = 1'b0;
        paddr = '0;
        pwdata = '0;
        burst_left = 0;
        hold_request = 1'b0;
        repeat (2) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        // reset defaults
        for (int i = 0; i < 8; i++)
            send_random_pixel();
        drain();

        // directed: unity noise weight, moderate gain, -25.5..0 dB
        cfg_all(32'h0001_0000, 56'd1 << 36, 48'd0, 1'b0, -16'sd6528, 16'd0);
        send_pixel(16'd0, 40'd0, 18'd0);
        send_pixel(16'd0, 40'hFF_FFFF_FFFF, 18'h3FFFF);
        send_pixel(16'd1, 40'd0, 18'd0);
        send_pixel(16'hFFFF, 40'd0, 18'h3FFFF);
        send_pixel(16'hFFFF, 40'hFF_FFFF_FFFF, 18'd0);
        send_pixel(16'd1000, 40'd1000 * 40'd1000 * 40'd256, 18'd65536);
        send_pixel(16'd1000, 40'd2000 * 40'd1000 * 40'd256, 18'd65536);
        send_pixel(16'd100, 40'd0, 18'd65536);
        send_pixel(16'd300, 40'd0, 18'd65536);
        send_pixel(16'd1024, 40'd0, 18'd65536);
        send_pixel(16'd1023, 40'd0, 18'd65536);
        send_pixel(16'd10, 40'd0, 18'd65536);
        send_pixel(16'h5555, 40'h55_5555_5555, 18'h15555);
        send_pixel(16'hAAAA, 40'hAA_AAAA_AAAA, 18'h2AAAA);
        drain();
        cfg_all(32'h0001_0000, 56'd1 << 36, 48'd0, 1'b1, -16'sd6528, -16'sd1280);
        send_pixel(16'd500, 40'd0, 18'h3FFFF);
        send_pixel(16'd500, 40'd0, 18'd0);
        send_pixel(16'd500, 40'd0, 18'd70000);
        send_pixel(16'd200, 40'd0, 18'd131072);
        send_pixel(16'hFFFF, 40'd0, 18'd1);
        drain();

        for (int p = 0; p < 8; p++)
        begin
            if (p == 0)
                cfg_all(32'hFFFF_FFFF, 56'hFF_FFFF_FFFF_FFFF, 48'h7FFF_FFFF_FFFF, 1'b1,
                        16'h7FFF, 16'h8000);
            else if (p == 1)
                cfg_all(32'd0, 56'd0, 48'h8000_0000_0000, 1'b0, 16'h8000, 16'h7FFF);
            else
            begin
                r = {$urandom, $urandom};
                flo = -16'($urandom_range(0, 16000));
                cfg_all($urandom >> $urandom_range(0, 31),
                        r[55:0] >> $urandom_range(10, 55),
                        48'($signed({$urandom, $urandom}) >>> $urandom_range(8, 63)),
                        1'($urandom),
                        flo,
                        ($urandom_range(0, 5) == 0) ? 16'($urandom)
                                                    : 16'(flo + 16'($urandom_range(1, 12000))));
            end
            for (int i = 0; i < 250; i++)
            begin
                if (p == 3 && i == 50)
                    hold_request <= 1'b1;
                send_random_pixel();
            end
            drain();
        end

        if (mismatch_count == 0 && pending_bytes == 0)
            $display("DONE: 0 errors");
        else
            $display("DONE: errors detected");
        $finish;
    end

endmodule
